// ----- src/contiguous_block_allocator_assert.svh -----
// Assertion macros shared by the allocator checker.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define CBA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("contiguous_block_allocator: check failed");

// next-cycle implication
`define CBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("contiguous_block_allocator: check failed");

`endif

// ----- src/cba_pkg.sv -----
// Shared types and codes of the contiguous block allocator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cba_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_BUSY  = 2'd3;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic capture;
		logic check;
		logic a_rd;
		logic a_eval;
		logic a_dec;
		logic a_split;
		logic r_rd;
		logic r_eval;
		logic r_got;
		logic n_got;
		logic r_wr;
		logic p_wr;
		logic out_load;
	} cba_cmd_t;

	typedef struct packed {
		logic is_release;
		logic slot_busy;
		logic slot_empty;
		logic addr_bad;
		logic h_end;
		logic hdr_zero;
		logic first_hit;
		logic found;
		logic exact;
		logic h_reach;
		logic n_in;
		logic merge_prev;
	} cba_stat_t;

endpackage

// ----- src/cba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/cba_datapath.sv -----
// Datapath of the allocator: header RAM, slot table, walk registers, result.
// Depends on cba_pkg and cba_ram; driven by cba_ctrl commands.
`timescale 1ns / 1ps

module cba_datapath #(
	parameter int POOL  = 512,
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cba_pkg::cba_cmd_t cmd,
	output cba_pkg::cba_stat_t stat,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_wr_data,
	input  logic              in_mode,
	input  logic [3:0]        in_pid,
	input  logic [8:0]        in_size,
	output logic [15:0]       out_data
);
	import cba_pkg::*;

	localparam int AW = $clog2(POOL);
	localparam int SW = AW + 1;
	localparam int CW = (AW + 2 > 11) ? AW + 2 : 11;
	localparam int HW = SW + 1;
	localparam int XW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [CW-1:0] POOL_C = CW'(POOL);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	logic [1:0]    policy_q;
	logic          mode_q;
	logic [3:0]    pid_q;
	logic [CW-1:0] need_q;
	logic [CW-1:0] h_q, pick_q, pick_size_q, r_q, size_r_q, prev_q, prev_size_q;
	logic          found_q, has_prev_q, prev_used_q, h0_init_q, rd_h0_s1;
	logic [1:0]    res_status_q;
	logic [CW-1:0] res_addr_q;
	logic          slot_valid_q [SLOTS];
	logic [SW-1:0] slot_addr_q  [SLOTS];

	logic [6:0]    pid_ext;
	logic [XW-1:0] idx;
	logic          pid_ok, slot_valid;
	logic [CW-1:0] slot_addr;
	logic [HW-1:0] rdata, wdata;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	logic [CW-1:0] hdr_size, wsize, nh, n_sum;
	logic          hdr_used, wused, fit;

	assign pid_ext    = {3'b000, pid_q};
	assign idx        = pid_ext[XW-1:0];
	assign pid_ok     = pid_ext < 7'(SLOTS);
	assign slot_valid = pid_ok && slot_valid_q[idx];
	assign slot_addr  = CW'(slot_addr_q[idx]);

	// header 0 reads as one free block over the pool until first written
	assign hdr_size = rd_h0_s1 ? POOL_C : CW'(rdata[SW-1:0]);
	assign hdr_used = rd_h0_s1 ? 1'b0 : rdata[SW];
	assign fit      = !hdr_used && (hdr_size >= need_q);
	assign nh       = pick_q + pick_size_q - need_q;
	assign n_sum    = r_q + hdr_size;

	always_comb begin
		raddr = h_q[AW-1:0];
		if (cmd.r_rd && h_q >= r_q) begin
			raddr = r_q[AW-1:0];
		end else if (cmd.r_got) begin
			raddr = n_sum[AW-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = pick_q[AW-1:0];
		wsize = pick_size_q;
		wused = 1'b1;
		if (cmd.a_dec && found_q) begin
			we = 1'b1;
			if (pick_size_q != need_q) begin
				wsize = pick_size_q - need_q;
				wused = 1'b0;
			end
		end else if (cmd.a_split) begin
			we    = 1'b1;
			waddr = nh[AW-1:0];
			wsize = need_q;
		end else if (cmd.r_wr) begin
			we    = 1'b1;
			waddr = r_q[AW-1:0];
			wsize = size_r_q;
			wused = 1'b0;
		end else if (cmd.p_wr) begin
			we    = 1'b1;
			waddr = prev_q[AW-1:0];
			wsize = prev_size_q + size_r_q;
			wused = 1'b0;
		end
	end

	assign wdata = {wused, wsize[SW-1:0]};

	cba_ram #(.WIDTH(HW), .DEPTH(POOL)) u_hdr_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_FIRST;
			h0_init_q <= 1'b1;
			rd_h0_s1  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				policy_q <= cfg_wr_data;
			end
			if (we && waddr == '0) begin
				h0_init_q <= 1'b0;
			end
			rd_h0_s1 <= h0_init_q && raddr == '0;
			if (cmd.check && mode_q == MODE_RELEASE && slot_valid) begin
				slot_valid_q[idx] <= 1'b0;
			end
			if (cmd.a_dec && found_q) begin
				slot_valid_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			pid_q  <= in_pid;
			need_q <= CW'(in_size) + ONE_C;
		end
		if (cmd.check) begin
			h_q        <= '0;
			found_q    <= 1'b0;
			has_prev_q <= 1'b0;
			r_q        <= slot_addr - ONE_C;
			if (mode_q == MODE_ALLOC) begin
				res_status_q <= ST_BUSY;
				res_addr_q   <= '0;
			end else if (!slot_valid) begin
				res_status_q <= ST_EMPTY;
				res_addr_q   <= '0;
			end else begin
				res_status_q <= ST_OK;
				res_addr_q   <= slot_addr;
			end
		end
		if (cmd.a_eval) begin
			h_q <= h_q + hdr_size;
			if (fit) begin
				case (policy_q)
					POL_BEST: begin
						if (!found_q || hdr_size < pick_size_q) begin
							pick_q      <= h_q;
							pick_size_q <= hdr_size;
							found_q     <= 1'b1;
						end
					end
					POL_WORST: begin
						if (!found_q || hdr_size > pick_size_q) begin
							pick_q      <= h_q;
							pick_size_q <= hdr_size;
							found_q     <= 1'b1;
						end
					end
					default: begin
						pick_q      <= h_q;
						pick_size_q <= hdr_size;
						found_q     <= 1'b1;
					end
				endcase
			end
		end
		if (cmd.a_dec) begin
			if (!found_q) begin
				res_status_q <= ST_NOFIT;
				res_addr_q   <= '0;
			end else if (pick_size_q == need_q) begin
				res_status_q      <= ST_OK;
				res_addr_q        <= pick_q + ONE_C;
				slot_addr_q[idx]  <= SW'(pick_q + ONE_C);
			end else begin
				res_status_q      <= ST_OK;
				res_addr_q        <= nh + ONE_C;
				slot_addr_q[idx]  <= SW'(nh + ONE_C);
			end
		end
		if (cmd.r_eval) begin
			if (hdr_size == '0) begin
				h_q <= r_q;
			end else begin
				prev_q      <= h_q;
				prev_size_q <= hdr_size;
				prev_used_q <= hdr_used;
				has_prev_q  <= 1'b1;
				h_q         <= h_q + hdr_size;
			end
		end
		if (cmd.r_got) begin
			size_r_q <= hdr_size;
		end
		if (cmd.n_got && !hdr_used && hdr_size != '0) begin
			size_r_q <= size_r_q + hdr_size;
		end
		if (cmd.out_load) begin
			out_data <= {5'b00000, res_addr_q[8:0], res_status_q};
		end
	end

	always_comb begin
		stat.is_release = mode_q == MODE_RELEASE;
		stat.slot_busy  = !pid_ok || slot_valid;
		stat.slot_empty = !slot_valid;
		stat.addr_bad   = slot_addr == '0 || slot_addr > POOL_C;
		stat.h_end      = h_q >= POOL_C;
		stat.hdr_zero   = hdr_size == '0;
		stat.first_hit  = fit && policy_q != POL_BEST && policy_q != POL_WORST;
		stat.found      = found_q;
		stat.exact      = pick_size_q == need_q;
		stat.h_reach    = h_q >= r_q;
		stat.n_in       = n_sum < POOL_C;
		stat.merge_prev = has_prev_q && !prev_used_q;
	end

endmodule

// ----- src/cba_ctrl.sv -----
// Controller state machine of the allocator: sequences walks and writes.
// Depends on cba_pkg; commands cba_datapath through cmd/stat structs.
`timescale 1ns / 1ps

module cba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output cba_pkg::cba_cmd_t  cmd,
	input  cba_pkg::cba_stat_t stat
);
	import cba_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_ARD    = 4'd2;
	localparam logic [3:0] S_AEVAL  = 4'd3;
	localparam logic [3:0] S_ADEC   = 4'd4;
	localparam logic [3:0] S_ASPLIT = 4'd5;
	localparam logic [3:0] S_RRD    = 4'd6;
	localparam logic [3:0] S_REVAL  = 4'd7;
	localparam logic [3:0] S_RGOT   = 4'd8;
	localparam logic [3:0] S_NGOT   = 4'd9;
	localparam logic [3:0] S_RWR    = 4'd10;
	localparam logic [3:0] S_PWR    = 4'd11;
	localparam logic [3:0] S_FINISH = 4'd12;

	logic [3:0] state_q, state_d;
	logic       m_tvalid_q;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (!stat.is_release) begin
					state_d = stat.slot_busy ? S_FINISH : S_ARD;
				end else if (stat.slot_empty || stat.addr_bad) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_RRD;
				end
			end
			S_ARD: begin
				cmd.a_rd = 1'b1;
				state_d  = stat.h_end ? S_ADEC : S_AEVAL;
			end
			S_AEVAL: begin
				if (stat.hdr_zero) begin
					state_d = S_ADEC;
				end else begin
					cmd.a_eval = 1'b1;
					state_d    = stat.first_hit ? S_ADEC : S_ARD;
				end
			end
			S_ADEC: begin
				cmd.a_dec = 1'b1;
				state_d   = (!stat.found || stat.exact) ? S_FINISH : S_ASPLIT;
			end
			S_ASPLIT: begin
				cmd.a_split = 1'b1;
				state_d     = S_FINISH;
			end
			S_RRD: begin
				cmd.r_rd = 1'b1;
				state_d  = stat.h_reach ? S_RGOT : S_REVAL;
			end
			S_REVAL: begin
				cmd.r_eval = 1'b1;
				state_d    = S_RRD;
			end
			S_RGOT: begin
				cmd.r_got = 1'b1;
				state_d   = stat.n_in ? S_NGOT : S_RWR;
			end
			S_NGOT: begin
				cmd.n_got = 1'b1;
				state_d   = S_RWR;
			end
			S_RWR: begin
				cmd.r_wr = 1'b1;
				state_d  = stat.merge_prev ? S_PWR : S_FINISH;
			end
			S_PWR: begin
				cmd.p_wr = 1'b1;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/contiguous_block_allocator.sv -----
// Top level of the contiguous block allocator.
// Depends on cba_pkg, cba_ctrl and cba_datapath.
`timescale 1ns / 1ps

// Manages a pool of POOL units tiled by blocks, each led by one header unit.
// An allocate beat (tuser 0) reserves request_size+1 units for a slot under
// the fit policy; a release beat (tuser 1) frees the slot's block and merges
// it with free neighbors. One result beat follows every input beat. Items are
// handled one at a time: an allocate visits the block headers in turn, a
// release visits the headers below the freed block, and a beat answered by
// a busy or empty slot status visits none. Each walk goes through the one
// read port of the header RAM. No clearing pass is needed after reset. A new
// beat is taken while the previous result still waits in the output register.
module contiguous_block_allocator #(
	parameter int POOL  = 512,
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,   // fit_policy
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // [3:0] process_id, [12:4] request_size
	input  logic        s_tuser,       // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata        // [1:0] status, [10:2] address
);
	import cba_pkg::*;

	cba_cmd_t  cmd;
	cba_stat_t stat;

	cba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cba_datapath #(.POOL(POOL), .SLOTS(SLOTS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_mode     (s_tuser),
		.in_pid      (s_tdata[3:0]),
		.in_size     (s_tdata[12:4]),
		.out_data    (m_tdata)
	);

endmodule

// ----- src/cba_checker.sv -----
// Port-level checker for the contiguous block allocator, bound to the top.
// Depends on cba_pkg and contiguous_block_allocator_assert.svh.
`timescale 1ns / 1ps
`include "contiguous_block_allocator_assert.svh"

module cba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import cba_pkg::*;

	`CBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CBA_ASSERT_IMPL(a_err_addr_zero, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[10:2] == 9'd0)
	`CBA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`CBA_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[15:11] == 5'd0)

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- verif/contiguous_block_allocator_tb.sv -----
// Self-checking testbench for contiguous_block_allocator.
// Drives allocate and release beats, models the pool in a scoreboard class and
// compares each result beat; depends on cba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module contiguous_block_allocator_tb;
	import cba_pkg::*;

	localparam int POOL_UNITS = 512;
	localparam int NUM_SLOTS  = 16;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_LEN = 3000;

	typedef struct {
		logic [1:0] status;
		logic [8:0] address;
	} alloc_result_t;

	class pool_scoreboard;
		int unsigned blk_size[POOL_UNITS];
		bit          blk_used[POOL_UNITS];
		bit          slot_valid[NUM_SLOTS];
		int unsigned slot_addr[NUM_SLOTS];
		logic [1:0]  policy;
		alloc_result_t pending[$];
		int mismatches;

		function void clear();
			foreach (blk_size[i]) begin
				blk_size[i] = 0;
				blk_used[i] = 0;
			end
			foreach (slot_valid[i]) begin
				slot_valid[i] = 0;
				slot_addr[i] = 0;
			end
			blk_size[0] = POOL_UNITS;
			policy = POL_FIRST;
			mismatches = 0;
			pending.delete();
		endfunction

		function alloc_result_t allocate(int unsigned pid, int unsigned rsize);
			alloc_result_t r;
			int unsigned need, h, pick, pick_sz, s, nh;
			bit found;
			need = rsize + 1;
			h = 0;
			pick = 0;
			pick_sz = 0;
			found = 0;
			r.status = ST_BUSY;
			r.address = '0;
			if (pid >= NUM_SLOTS || slot_valid[pid]) return r;
			while (h < POOL_UNITS) begin
				s = blk_size[h];
				if (s == 0) break;
				if (!blk_used[h] && s >= need) begin
					if (policy == POL_BEST) begin
						if (!found || s < pick_sz) begin
							pick = h; pick_sz = s; found = 1;
						end
					end else if (policy == POL_WORST) begin
						if (!found || s > pick_sz) begin
							pick = h; pick_sz = s; found = 1;
						end
					end else begin
						pick = h; pick_sz = s; found = 1;
						break;
					end
				end
				h += s;
			end
			if (!found) begin
				r.status = ST_NOFIT;
				return r;
			end
			if (pick_sz == need) begin
				blk_used[pick] = 1;
			end else begin
				// carve from the high end, low part stays free
				nh = pick + pick_sz - need;
				blk_size[pick] = pick_sz - need;
				blk_size[nh] = need;
				blk_used[nh] = 1;
				pick = nh;
			end
			slot_valid[pid] = 1;
			slot_addr[pid] = pick + 1;
			r.status = ST_OK;
			r.address = 9'(pick + 1);
			return r;
		endfunction

		function alloc_result_t release_slot(int unsigned pid);
			alloc_result_t r;
			int unsigned a, hr, h, prev, n, s;
			bit has_prev;
			h = 0;
			prev = 0;
			has_prev = 0;
			r.status = ST_EMPTY;
			r.address = '0;
			if (pid >= NUM_SLOTS || !slot_valid[pid]) return r;
			a = slot_addr[pid];
			slot_valid[pid] = 0;
			slot_addr[pid] = 0;
			r.status = ST_OK;
			r.address = 9'(a);
			if (a == 0 || a > POOL_UNITS) return r;
			hr = a - 1;
			while (h < hr) begin
				s = blk_size[h];
				if (s == 0) break;
				prev = h;
				has_prev = 1;
				h += s;
			end
			blk_used[hr] = 0;
			n = hr + blk_size[hr];
			if (n < POOL_UNITS && !blk_used[n] && blk_size[n] != 0)
				blk_size[hr] += blk_size[n];
			if (has_prev && !blk_used[prev])
				blk_size[prev] += blk_size[hr];
			return r;
		endfunction

		function void note_input(logic mode, logic [3:0] pid, logic [8:0] rsize);
			pending.push_back(mode == MODE_RELEASE ? release_slot(pid) : allocate(pid, rsize));
		endfunction

		function void check_result(logic [15:0] data);
			alloc_result_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d address %0d",
						data[1:0], data[10:2]);
				return;
			end
			exp_r = pending.pop_front();
			if (data[1:0] !== exp_r.status || data[10:2] !== exp_r.address
					|| data[15:11] !== '0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected status %0d address %0d, got status %0d address %0d",
						exp_r.status, exp_r.address, data[1:0], data[10:2]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	pool_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	int hold_cycles;
	longint cycle_count;

	contiguous_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver: random stalls, plus one long hold-off once requested.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if (recv_hold && hold_cycles < HOLD_LEN) begin
			hold_cycles <= hold_cycles + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Leaves tvalid high after the beat; the next idle cycle or drain drops it.
	task automatic send_beat(logic mode, logic [3:0] pid, logic [8:0] rsize);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {3'b000, rsize, pid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(mode, pid, rsize);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * POOL_UNITS + 20) @(posedge clk);
	endtask

	task automatic set_policy(logic [1:0] pol);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= pol;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.policy = pol;
	endtask

	// Random mix of allocate and release beats on valid slot ids, mostly with small sizes.
	task automatic random_burst(int count);
		logic mode;
		logic [3:0] pid;
		logic [8:0] rsize;
		for (int i = 0; i < count; i++) begin
			mode = 1'($urandom_range(1));
			pid = 4'($urandom_range(NUM_SLOTS - 1));
			case ($urandom_range(9))
				0: rsize = 9'($urandom_range(511));
				1: rsize = 9'($urandom_range(511, 200));
				2: rsize = 9'd0;
				default: rsize = 9'($urandom_range(40));
			endcase
			send_beat(mode, pid, rsize);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, busy and empty slots, zero size, oversize, exact fit.
		send_beat(MODE_RELEASE, 4'd0, 9'd0);
		send_beat(MODE_ALLOC, 4'd0, 9'd0);
		send_beat(MODE_ALLOC, 4'd0, 9'd5);
		send_beat(MODE_ALLOC, 4'd15, 9'd511);
		send_beat(MODE_ALLOC, 4'd1, 9'd100);
		send_beat(MODE_ALLOC, 4'd2, 9'd10);
		send_beat(MODE_ALLOC, 4'd3, 9'd50);
		send_beat(MODE_RELEASE, 4'd1, 9'h1ff);
		send_beat(MODE_RELEASE, 4'd0, 9'd0);
		send_beat(MODE_RELEASE, 4'd3, 9'd0);
		send_beat(MODE_RELEASE, 4'd2, 9'd0);
		send_beat(MODE_ALLOC, 4'd15, 9'd511);
		send_beat(MODE_ALLOC, 4'd15, 9'd0);
		send_beat(MODE_RELEASE, 4'd15, 9'd0);
		send_beat(MODE_ALLOC, 4'd14, 9'd510);
		send_beat(MODE_ALLOC, 4'd13, 9'd0);
		send_beat(MODE_RELEASE, 4'd14, 9'd0);
		send_beat(MODE_RELEASE, 4'd13, 9'd0);

		for (int pol = 0; pol < 4; pol++) begin
			set_policy(pol[1:0]);
			send_idle_pct = 6;
			recv_idle_pct = 67;
			random_burst(100);
			send_idle_pct = 67;
			recv_idle_pct = 6;
			random_burst(100);
			send_idle_pct = 0;
			recv_idle_pct = 0;
			random_burst(80);
		end

		// Long receiver hold-off while items keep coming, then a full pause.
		recv_hold = 1;
		random_burst(20);
		drain();
		set_policy(POL_BEST);
		random_burst(20);
		set_policy(POL_FIRST);
		random_burst(10);

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
